// ----- hdl/spq_pkg.sv -----
// spq_pkg: types, constants and status codes of the sorted priority queue
// used by spq_cell and sorted_priority_queue_unit; no dependencies
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W       = 32;
    localparam int PRIO_W      = 8;
    localparam int OCC_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 48;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // shared command for every cell of the chain
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t new_entry;
    } cell_ctl_t;

endpackage

// ----- hdl/sorted_priority_queue_unit.sv -----
// sorted_priority_queue_unit: top level of the sorted priority queue
// depends on spq_pkg and spq_cell
//
// A queue of up to QUEUE_DEPTH jobs (32-bit tag, 8-bit priority) kept in a
// row of cells ordered from highest to lowest priority, equal priorities in
// arrival order. A word on the slave side with tuser low inserts a job, with
// tuser high removes the front job. On an insert each cell compares its own
// priority with the new one and keeps its job, takes the new job or takes its
// left neighbour's job; on a remove it takes its right neighbour's job. One word
// is taken per cycle while the output register is empty or being read; the
// result word appears on the master side in the cycle after acceptance, held
// in that register, and a new word is taken in the same cycle that the waiting
// result is taken. An insert into a full queue is dropped with status full, a
// remove from an empty queue returns status empty with zero tag and priority.
module sorted_priority_queue_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spq_pkg::IN_DATA_W-1:0]   s_tdata,   // job_tag, priority_req
    input  logic                            s_tuser,   // func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spq_pkg::OUT_DATA_W-1:0]  m_tdata    // status, out_job_tag,
                                                       // out_priority, occupancy, zero fill
);
    import spq_pkg::*;

    logic      s_accept;
    logic      is_remove;
    entry_t    in_entry;
    cell_ctl_t ctl;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic      out_valid_reg;
    logic      out_valid_next;
    status_t   out_status_reg;
    status_t   out_status_next;
    entry_t    out_entry_reg;
    entry_t    out_entry_next;
    logic [OCC_W-1:0] out_occ_reg;
    logic [OCC_W-1:0] out_occ_next;

    entry_t    cell_entry  [QUEUE_DEPTH];
    logic      cell_behind [QUEUE_DEPTH];

    logic      is_full;
    logic      is_empty;

    // output register frees as soon as its word is taken
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign is_remove = (s_tuser == FUNC_REMOVE);

    assign in_entry.tag  = s_tdata[TAG_W-1:0];
    assign in_entry.prio = s_tdata[TAG_W+PRIO_W-1:TAG_W];

    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    assign ctl.insert    = s_accept && !is_remove && !is_full;
    assign ctl.remove    = s_accept && is_remove && !is_empty;
    assign ctl.new_entry = in_entry;

    // chain of cells, slot 0 at the front
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++)
    begin : g_cell
        logic   occ;
        logic   lb;
        entry_t le;
        entry_t re;

        assign occ = (count_reg > CNT_W'(gi));

        if (gi == 0)
        begin : g_first
            assign lb = 1'b0;
            assign le = in_entry;
        end
        else
        begin : g_mid
            assign lb = cell_behind[gi-1];
            assign le = cell_entry[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1)
        begin : g_last
            assign re = cell_entry[gi];
        end
        else
        begin : g_inner
            assign re = cell_entry[gi+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (occ),
            .left_behind (lb),
            .left_entry  (le),
            .right_entry (re),
            .behind      (cell_behind[gi]),
            .entry       (cell_entry[gi])
        );
    end

    // fill count and result word
    always_comb
    begin
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_occ_next    = out_occ_reg;

        if (ctl.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.remove)
        begin
            count_next = count_reg - 1'b1;
        end

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (s_accept)
        begin
            out_valid_next = 1'b1;
            out_entry_next = '0;
            if (is_remove)
            begin
                if (is_empty)
                begin
                    out_status_next = ST_EMPTY;
                end
                else
                begin
                    out_status_next = ST_OK;
                    out_entry_next  = cell_entry[0];
                end
            end
            else
            begin
                out_status_next = is_full ? ST_FULL : ST_OK;
            end
            // occupancy reports the fill count after this operation
            out_occ_next = OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_occ_reg    <= out_occ_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_occ_reg, out_entry_reg.prio, out_entry_reg.tag,
                       out_status_reg};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count above queue depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !is_remove && !is_full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted insert did not grow the queue");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && is_remove && is_empty) |=> (out_status_reg == ST_EMPTY))
        else $error("remove from empty queue without empty status");

    a_front_order: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && is_remove && (count_reg > CNT_W'(1)))
        |=> (out_entry_reg.prio >= cell_entry[0].prio))
        else $error("new front job outranks the removed one");
`endif

endmodule

// ----- hdl/spq_cell.sv -----
// spq_cell: one slot of the sorted queue chain, holding a single job
// depends on spq_pkg
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic               occupied,     // slot lies below the fill count
    input  logic               left_behind,  // left neighbour moves back this cycle
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               behind,       // new job goes at or before this slot
    output spq_pkg::entry_t    entry
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // empty slots and lower-priority jobs sit behind the new job
    assign behind = !occupied || (entry_reg.prio < ctl.new_entry.prio);
    assign entry  = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctl.insert)
        begin
            if (left_behind)
            begin
                entry_next = left_entry;
            end
            else if (behind)
            begin
                entry_next = ctl.new_entry;
            end
        end
        else if (ctl.remove)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- tb/sorted_priority_queue_unit_test.sv -----
// sorted_priority_queue_unit_test: self-checking bench for the sorted priority queue
// drives insert and remove words, predicts every result word, compares field by field
// depends on spq_pkg and sorted_priority_queue_unit
module sorted_priority_queue_unit_test;

    import spq_pkg::*;

    localparam int RAND_ITEMS  = 700;
    localparam int DIR_ROWS    = 25;
    localparam int HOLD_CYCLES = 60;   // long receiver hold-off
    localparam int HOLD_AT     = 150;  // random item that starts the hold-off
    localparam int PAUSE_AT    = 400;  // random item after which the sender drains
    localparam int TAIL_ITEMS  = 80;   // closing items with no idling

    // one result word, fields as they leave the block
    typedef struct packed {
        status_t           status;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]  occ;
    } job_result_t;

    // one row of directed stimulus; known rows carry a typed result
    typedef struct packed {
        func_t             op;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
        logic              known;
        job_result_t       res;
    } stim_row_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // typed expectation travelling alongside the word on offer
    logic                  row_known  = 1'b0;
    job_result_t           row_result = '0;

    // shadow copy of the queue contents
    logic [TAG_W-1:0]      shadow_tags  [QUEUE_DEPTH];
    logic [PRIO_W-1:0]     shadow_prios [QUEUE_DEPTH];
    int                    shadow_count = 0;

    job_result_t           pending_results [$];

    int  errors        = 0;
    int  words_checked = 0;
    int  n_inserts     = 0;
    int  n_removes     = 0;
    int  n_full        = 0;
    int  n_empty       = 0;
    bit  quiet_tail    = 1'b0;
    bit  no_gap        = 1'b0;
    bit  hold_off_req  = 1'b0;

    sorted_priority_queue_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // job_tag, priority_req
        .s_tuser  (s_tuser),   // func
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // status, out_job_tag, out_priority, occupancy, zero fill
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // overall watchdog, far beyond the slowest correct run
    initial
    begin
        #400000;
        $display("sorted_priority_queue_unit test failed");
        $finish;
    end

    // applies one operation to the shadow queue and returns the result word
    function automatic job_result_t predict_queue_op(func_t op, logic [TAG_W-1:0] tag,
                                                     logic [PRIO_W-1:0] prio);
        job_result_t r;
        int          pos;
        r        = '0;
        r.status = ST_OK;
        if (op == FUNC_INSERT)
        begin
            n_inserts++;
            if (shadow_count >= QUEUE_DEPTH)
            begin
                r.status = ST_FULL;
                n_full++;
            end
            else
            begin
                // new job goes behind every job of equal or higher priority
                pos = 0;
                while (pos < shadow_count && shadow_prios[pos] >= prio)
                    pos++;
                for (int k = shadow_count; k > pos; k--)
                begin
                    shadow_tags[k]  = shadow_tags[k-1];
                    shadow_prios[k] = shadow_prios[k-1];
                end
                shadow_tags[pos]  = tag;
                shadow_prios[pos] = prio;
                shadow_count++;
            end
        end
        else
        begin
            n_removes++;
            if (shadow_count == 0)
            begin
                r.status = ST_EMPTY;
                n_empty++;
            end
            else
            begin
                r.tag  = shadow_tags[0];
                r.prio = shadow_prios[0];
                for (int k = 1; k < shadow_count; k++)
                begin
                    shadow_tags[k-1]  = shadow_tags[k];
                    shadow_prios[k-1] = shadow_prios[k];
                end
                shadow_count--;
            end
        end
        r.occ = OCC_W'(shadow_count);
        return r;
    endfunction

    // scoreboard: result words are checked before the word accepted on the
    // same edge is predicted, so an early result can never match its own input
    always @(posedge clk)
    begin
        job_result_t exp_r;
        job_result_t got_r;
        job_result_t pred;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_r.status = status_t'(m_tdata[1:0]);
            got_r.tag    = m_tdata[33:2];
            got_r.prio   = m_tdata[41:34];
            got_r.occ    = m_tdata[46:42];
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing expected, actual %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                words_checked++;
                if (got_r.status != exp_r.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, exp_r.status, got_r.status);
                    errors++;
                end
                if (got_r.tag != exp_r.tag)
                begin
                    $display("%0t: job tag mismatch, expected %h, actual %h",
                             $time, exp_r.tag, got_r.tag);
                    errors++;
                end
                if (got_r.prio != exp_r.prio)
                begin
                    $display("%0t: priority mismatch, expected %0d, actual %0d",
                             $time, exp_r.prio, got_r.prio);
                    errors++;
                end
                if (got_r.occ != exp_r.occ)
                begin
                    $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                             $time, exp_r.occ, got_r.occ);
                    errors++;
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            pred = predict_queue_op(func_t'(s_tuser), s_tdata[31:0], s_tdata[39:32]);
            pending_results.push_back(row_known ? row_result : pred);
        end
    end

    // receiver: random stall bursts, one long hold-off on request, none at the tail
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // offers one word, waits until it is accepted, then may drain or idle before returning
    task automatic send_word(input func_t op, input logic [TAG_W-1:0] tag,
                             input logic [PRIO_W-1:0] prio, input logic known,
                             input job_result_t res, input bit drain_after);
        s_tvalid   <= 1'b1;
        s_tuser    <= op;
        s_tdata    <= {prio, tag};
        row_known  <= known;
        row_result <= res;
        do
            @(posedge clk);
        while (!s_tready);
        if (drain_after)
        begin
            // sender stands still until every expected word has come back;
            // the first check follows a clock edge so the word just accepted is already queued
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (pending_results.size() != 0);
        end
        else if (!quiet_tail && !no_gap && $urandom_range(0, 6) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        stim_row_t        dir_rows [DIR_ROWS];
        int               mix;
        int               prio_mode;
        int               rm_pct;
        func_t            op;
        logic [PRIO_W-1:0] prio;

        // empty remove, extremes, tie order, then a full fill and a dropped insert
        dir_rows = '{
            '{FUNC_REMOVE, 32'h0000_0000, 8'd0,   1'b1, '{ST_EMPTY, 32'h0,         8'd0,   5'd0}},
            '{FUNC_INSERT, 32'hFFFF_FFFF, 8'd255, 1'b1, '{ST_OK,    32'h0,         8'd0,   5'd1}},
            '{FUNC_INSERT, 32'h0000_0000, 8'd0,   1'b1, '{ST_OK,    32'h0,         8'd0,   5'd2}},
            '{FUNC_INSERT, 32'h4141_4141, 8'd255, 1'b0, '0},
            '{FUNC_REMOVE, 32'h1234_5678, 8'd77,  1'b1, '{ST_OK,    32'hFFFF_FFFF, 8'd255, 5'd2}},
            '{FUNC_REMOVE, 32'h0000_0000, 8'd0,   1'b0, '0},
            '{FUNC_REMOVE, 32'hFFFF_FFFF, 8'd255, 1'b0, '0},
            '{FUNC_REMOVE, 32'hDEAD_BEEF, 8'd9,   1'b1, '{ST_EMPTY, 32'h0,         8'd0,   5'd0}},
            '{FUNC_INSERT, 32'h4A4F_4230, 8'd10,  1'b0, '0},
            '{FUNC_INSERT, 32'h4A4F_4231, 8'd200, 1'b0, '0},
            '{FUNC_INSERT, 32'h4A4F_4232, 8'd10,  1'b0, '0},
            '{FUNC_INSERT, 32'h4A4F_4233, 8'd255, 1'b0, '0},
            '{FUNC_INSERT, 32'h4A4F_4234, 8'd0,   1'b0, '0},
            '{FUNC_INSERT, 32'h4A4F_4235, 8'd128, 1'b0, '0},
            '{FUNC_INSERT, 32'h4A4F_4236, 8'd127, 1'b0, '0},
            '{FUNC_INSERT, 32'h4A4F_4237, 8'd10,  1'b0, '0},
            '{FUNC_INSERT, 32'h4A4F_4238, 8'd1,   1'b0, '0},
            '{FUNC_INSERT, 32'h4A4F_4239, 8'd254, 1'b0, '0},
            '{FUNC_INSERT, 32'h4A4F_423A, 8'd200, 1'b0, '0},
            '{FUNC_INSERT, 32'h4A4F_423B, 8'd0,   1'b0, '0},
            '{FUNC_INSERT, 32'h4A4F_423C, 8'd64,  1'b0, '0},
            '{FUNC_INSERT, 32'h4A4F_423D, 8'd255, 1'b0, '0},
            '{FUNC_INSERT, 32'h4A4F_423E, 8'd10,  1'b0, '0},
            '{FUNC_INSERT, 32'h4A4F_423F, 8'd3,   1'b0, '0},
            '{FUNC_INSERT, 32'hC0FF_EE00, 8'd99,  1'b1, '{ST_FULL,  32'h0,         8'd0,   5'd16}}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_rows[r])
            send_word(dir_rows[r].op, dir_rows[r].tag, dir_rows[r].prio,
                      dir_rows[r].known, dir_rows[r].res, 1'b0);

        // random part in segments that lean towards filling, draining or neither,
        // with priorities spread wide, crowded into a few tie values, or at extremes
        mix       = 0;
        prio_mode = 0;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 40 == 0)
            begin
                mix       = $urandom_range(0, 2);
                prio_mode = $urandom_range(0, 2);
            end
            quiet_tail = (i >= RAND_ITEMS - TAIL_ITEMS);
            if (i == HOLD_AT)
            begin
                hold_off_req = 1'b1;
                no_gap       = 1'b1;
            end
            if (i == HOLD_AT + 30)
                no_gap = 1'b0;
            rm_pct = (mix == 0) ? 15 : (mix == 1) ? 85 : 50;
            op     = ($urandom_range(0, 99) < rm_pct) ? FUNC_REMOVE : FUNC_INSERT;
            case (prio_mode)
                0:       prio = PRIO_W'($urandom_range(0, 255));
                1:       prio = PRIO_W'($urandom_range(0, 3));
                default:
                    case ($urandom_range(0, 3))
                        0:       prio = 8'd0;
                        1:       prio = 8'd255;
                        2:       prio = 8'd128;
                        default: prio = PRIO_W'($urandom_range(0, 255));
                    endcase
            endcase
            send_word(op, $urandom, prio, 1'b0, '0, i == PAUSE_AT);
        end
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (8) @(posedge clk);

        $display("covered %0d inserts (%0d into a full queue) and %0d removes (%0d on empty)",
                 n_inserts, n_full, n_removes, n_empty);
        $display("%0d result words checked, %0d mismatches", words_checked, errors);
        if (errors == 0)
            $display("sorted_priority_queue_unit test passed");
        else
            $display("sorted_priority_queue_unit test failed");
        $finish;
    end

endmodule
